>>> rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types, codes and the crc-16/xmodem byte step of the frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int unsigned PAYLOAD_DEPTH = 256;
    localparam int unsigned PAY_AW        = $clog2(PAYLOAD_DEPTH);

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // word kinds on the input channel
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // event codes on the result channel
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ACCEPT    = 3'd1;
    localparam logic [2:0] EV_CRCFAIL   = 3'd2;
    localparam logic [2:0] EV_FRAMEFAIL = 3'd3;
    localparam logic [2:0] EV_IGNORED   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_HEADER_FIRST   = 3'd0;
    localparam logic [2:0] CFG_HEADER_SECOND  = 3'd1;
    localparam logic [2:0] CFG_TRAILER_FIRST  = 3'd2;
    localparam logic [2:0] CFG_TRAILER_SECOND = 3'd3;
    localparam logic [2:0] CFG_CRC_ENABLE     = 3'd4;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] trailer_first;
        logic [7:0] trailer_second;
        logic       crc_enable;
    } t_cfg;

    // parser view of one result word, payload byte excluded
    typedef struct packed {
        logic [2:0]  event_res;
        logic        frame_ready;
        logic [7:0]  frm_id;
        logic [7:0]  frame_length;
        logic [15:0] received_crc;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [PAY_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sfr_payload_ram.sv
// ----------------------------------------------------------------------------
// sfr_payload_ram
// payload store, one write and one registered read port, write-first
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_payload_ram (
    input  wire logic                      i_clk,
    input  wire sfr_pkg::t_wr              i_wr,
    input  wire logic                      i_rd_en,
    input  wire logic [sfr_pkg::PAY_AW-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);
    import sfr_pkg::*;

    logic [7:0] r_mem [PAYLOAD_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // a read issued while the same entry is written returns the new byte
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.we && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser
// frame state machine, header/trailer match, running crc and frame stores
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [1:0]       i_kind,
    input  wire logic [7:0]       i_data_byte,
    input  wire sfr_pkg::t_cfg    i_cfg,
    output sfr_pkg::t_result      o_result,
    output sfr_pkg::t_wr          o_wr
);
    import sfr_pkg::*;

    typedef enum logic [8:0] {
        ST_HEAD0 = 9'b0_0000_0001,
        ST_HEAD1 = 9'b0_0000_0010,
        ST_ID    = 9'b0_0000_0100,
        ST_LEN   = 9'b0_0000_1000,
        ST_DATA  = 9'b0_0001_0000,
        ST_CRC0  = 9'b0_0010_0000,
        ST_CRC1  = 9'b0_0100_0000,
        ST_END0  = 9'b0_1000_0000,
        ST_END1  = 9'b1_0000_0000
    } t_state;

    t_state      r_state, n_state;
    logic        r_ready, n_ready;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_crc_store, n_crc_store;
    logic [2:0]  ev;
    logic [7:0]  count_inc;

    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_state     = r_state;
        n_ready     = r_ready;
        n_id        = r_id;
        n_len       = r_len;
        n_count     = r_count;
        n_crc       = r_crc;
        n_crc_store = r_crc_store;
        ev          = EV_NONE;
        o_wr.we     = 1'b0;
        o_wr.addr   = PAY_AW'(r_count);
        o_wr.data   = i_data_byte;
        if (i_step) begin
            case (i_kind)
                KIND_BYTE: begin
                    if (r_ready) begin
                        ev = EV_IGNORED;
                    end else begin
                        unique case (r_state)
                            ST_HEAD0: begin
                                if (i_data_byte == i_cfg.header_first) n_state = ST_HEAD1;
                            end
                            ST_HEAD1: begin
                                if (i_data_byte == i_cfg.header_second) begin
                                    n_state = ST_ID;
                                end else begin
                                    n_state = ST_HEAD0;
                                    ev      = EV_FRAMEFAIL;
                                end
                            end
                            ST_ID: begin
                                n_id    = i_data_byte;
                                n_state = ST_LEN;
                            end
                            ST_LEN: begin
                                n_len   = i_data_byte;
                                n_count = 8'd0;
                                n_crc   = 16'd0;
                                // empty payload goes straight to the crc bytes
                                n_state = (i_data_byte == 8'd0) ? ST_CRC0 : ST_DATA;
                            end
                            ST_DATA: begin
                                o_wr.we = 1'b1;
                                n_crc   = crc16_fold(r_crc, i_data_byte);
                                n_count = count_inc;
                                if (count_inc >= r_len) n_state = ST_CRC0;
                            end
                            ST_CRC0: begin
                                n_crc_store = {r_crc_store[15:8], i_data_byte};
                                n_state     = ST_CRC1;
                            end
                            ST_CRC1: begin
                                n_crc_store = {i_data_byte, r_crc_store[7:0]};
                                n_state     = ST_END0;
                            end
                            ST_END0: begin
                                if (i_data_byte == i_cfg.trailer_first) begin
                                    n_state = ST_END1;
                                end else begin
                                    n_state = ST_HEAD0;
                                    ev      = EV_FRAMEFAIL;
                                end
                            end
                            ST_END1: begin
                                n_state = ST_HEAD0;
                                if (i_data_byte != i_cfg.trailer_second) begin
                                    ev = EV_FRAMEFAIL;
                                end else if (i_cfg.crc_enable && (r_crc != r_crc_store)) begin
                                    ev = EV_CRCFAIL;
                                end else begin
                                    n_ready = 1'b1;
                                    ev      = EV_ACCEPT;
                                end
                            end
                            default: n_state = ST_HEAD0;
                        endcase
                    end
                end
                KIND_RELEASE: n_ready = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HEAD0;
            r_ready     <= 1'b0;
            r_id        <= 8'd0;
            r_len       <= 8'd0;
            r_count     <= 8'd0;
            r_crc       <= 16'd0;
            r_crc_store <= 16'd0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_id        <= n_id;
            r_len       <= n_len;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_crc_store <= n_crc_store;
        end
    end

    assign o_result.event_res    = ev;
    assign o_result.frame_ready  = n_ready;
    assign o_result.frm_id       = n_id;
    assign o_result.frame_length = n_len;
    assign o_result.received_crc = n_crc_store;

endmodule

`default_nettype wire

>>> rtl/serial_frame_receiver_crc16_top.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16_top
// byte stream frame receiver with crc-16/xmodem check and payload read-back
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                  payload
//   --------  ---------  -------------------------  ---------------------------------
//   in        sink       i_in_valid / o_in_ready    i_kind, i_data_byte, i_read_index
//   out       source     o_out_valid / i_out_ready  o_event_res .. o_received_crc
//   cfg       sink       i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// one word per cycle sustained while the result side takes its words; a result
// appears once its word has passed the input register, then the result register
// the input register also holds the registered read of the payload memory,
// issued at accept time with write-first forwarding from the word ahead
// reset clears control state and frame stores but not the payload memory;
// the user must only read it where a frame has written it (the block does not check)
// a stalled result holds the input register; o_in_ready stays high while
// the input register is empty or moving into the result register
//
`default_nettype none

module serial_frame_receiver_crc16_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // input words
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_read_index,
    // result words
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_event_res,
    output logic             o_frame_ready,
    output logic [7:0]       o_frm_id,
    output logic [7:0]       o_frame_length,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_received_crc
);
    import sfr_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first   <= 8'd0;
            r_cfg.header_second  <= 8'd0;
            r_cfg.trailer_first  <= 8'd0;
            r_cfg.trailer_second <= 8'd0;
            r_cfg.crc_enable     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:   r_cfg.header_first   <= i_cfg_data;
                CFG_HEADER_SECOND:  r_cfg.header_second  <= i_cfg_data;
                CFG_TRAILER_FIRST:  r_cfg.trailer_first  <= i_cfg_data;
                CFG_TRAILER_SECOND: r_cfg.trailer_second <= i_cfg_data;
                CFG_CRC_ENABLE:     r_cfg.crc_enable     <= i_cfg_data[0];
                default: ;      // writes beyond the register list are dropped
            endcase
        end
    end

    // handshake control
    logic in_take;      // word accepted into the input register
    logic advance;      // input register word processed into the result register
    logic r_in_valid;
    logic r_out_valid;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input register payload
    logic [1:0] r_in_kind;
    logic [7:0] r_in_data;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind <= i_kind;
            r_in_data <= i_data_byte;
        end
    end

    // parser and payload store
    t_result    result;
    t_wr        wr;
    logic [7:0] rd_data;

    sfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_kind      (r_in_kind),
        .i_data_byte (r_in_data),
        .i_cfg       (r_cfg),
        .o_result    (result),
        .o_wr        (wr)
    );

    sfr_payload_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (in_take),
        .i_rd_addr (PAY_AW'(i_read_index)),
        .o_rd_data (rd_data)
    );

    // result register
    t_result    r_out;
    logic [7:0] r_out_payload;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out         <= result;
            r_out_payload <= (r_in_kind == KIND_READ) ? rd_data : 8'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_out.event_res;
    assign o_frame_ready  = r_out.frame_ready;
    assign o_frm_id       = r_out.frm_id;
    assign o_frame_length = r_out.frame_length;
    assign o_payload_byte = r_out_payload;
    assign o_received_crc = r_out.received_crc;

endmodule

`default_nettype wire

>>> rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// port-level checks on the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_event_res,
    input wire logic        i_frame_ready,
    input wire logic [7:0]  i_frm_id,
    input wire logic [15:0] i_received_crc
);
    import sfr_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_event_res) && $stable(i_frm_id)
            && $stable(i_received_crc))
        else $error("result word changed while stalled");

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an accepted frame raises the ready flag
    a_accept_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_res == EV_ACCEPT) |-> i_frame_ready)
        else $error("frame accepted without ready flag");

    // bytes are ignored only while a frame waits for release
    a_ignored_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_res == EV_IGNORED) |-> i_frame_ready)
        else $error("byte ignored without ready flag");

    // only defined event codes show up on a valid result word
    a_fail_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_res == EV_NONE) || (i_event_res == EV_ACCEPT)
            || (i_event_res == EV_CRCFAIL) || (i_event_res == EV_FRAMEFAIL)
            || (i_event_res == EV_IGNORED))
        else $error("unknown event code");

endmodule

bind serial_frame_receiver_crc16_top sfr_checker u_sfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_event_res    (o_event_res),
    .i_frame_ready  (o_frame_ready),
    .i_frm_id       (o_frm_id),
    .i_received_crc (o_received_crc)
);

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the serial frame receiver with crc-16/xmodem check
// a directed table runs first: hunting, header and trailer mismatches, a crc
// failure, a zero-length frame, an accepted frame, a byte while held, a read,
// a release with nothing held and the spare word kind
// random frames follow under several register settings, with random content
// and some corrupted; every result word is compared field by field against
// a cycle-free predictor of the parser
// ----------------------------------------------------------------------------
module tb_top;

    import sfr_pkg::*;

    // kind 3 has no meaning in the block; it must answer with no event
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // frame delimiters used by the directed table
    localparam logic [7:0] DIR_H1 = 8'hA5;
    localparam logic [7:0] DIR_H2 = 8'h5A;
    localparam logic [7:0] DIR_T1 = 8'h0D;
    localparam logic [7:0] DIR_T2 = 8'h0A;

    localparam int N_RAND_PHASES = 5;
    localparam int PHASE_WORDS   = 350;
    localparam int HOLD_AT       = 600;     // words in before the long sink hold-off
    localparam int HOLD_CYCLES   = 200;
    localparam int RUN_LIMIT     = 1600000; // time limit for the whole run

    typedef enum logic [3:0] {
        PS_HEAD0, PS_HEAD1, PS_ID, PS_LEN, PS_DATA, PS_CRC0, PS_CRC1, PS_END0, PS_END1
    } t_parse_state;

    typedef enum logic [2:0] {
        DF_NONE, DF_HEADER2, DF_TRAILER1, DF_TRAILER2, DF_CRC
    } t_frame_defect;

    // where a directed byte comes from: the table, or the crc built up so far
    typedef enum logic [1:0] {DS_LIT, DS_CRC_LO, DS_CRC_HI} t_byte_src;

    typedef struct packed {
        logic [1:0] kind;
        t_byte_src  src;
        logic [7:0] data;
        logic [7:0] idx;
        logic       typed;  // event below is fixed by hand, else predicted
        logic [2:0] ev;
    } t_stim_row;

    typedef struct packed {
        logic [2:0]  ev;
        logic        rdy;
        logic [7:0]  id;
        logic [7:0]  len;
        logic [7:0]  pb;
        logic [15:0] crc;
    } t_rx_result;

    localparam t_stim_row DIRECTED [32] = '{
        // hunting: wrong first header, release with nothing held, spare kind
        '{KIND_BYTE,    DS_LIT,    8'h00,  8'h00, 1'b1, EV_NONE},
        '{KIND_RELEASE, DS_LIT,    8'hFF,  8'hFF, 1'b1, EV_NONE},
        '{KIND_SPARE,   DS_LIT,    8'h5A,  8'hA5, 1'b1, EV_NONE},
        // wrong second header drops back to hunting
        '{KIND_BYTE,    DS_LIT,    DIR_H1, 8'h00, 1'b1, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h00,  8'hFF, 1'b1, EV_FRAMEFAIL},
        // zero-length frame broken on its first trailer byte
        '{KIND_BYTE,    DS_LIT,    DIR_H1, 8'h00, 1'b1, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    DIR_H2, 8'h00, 1'b1, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h7F,  8'h80, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h00,  8'h7F, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h00,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h00,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'hFF,  8'h00, 1'b1, EV_FRAMEFAIL},
        // zero-length frame carrying a nonzero crc: crc failure
        '{KIND_BYTE,    DS_LIT,    DIR_H1, 8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    DIR_H2, 8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h01,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h00,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h34,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h12,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    DIR_T1, 8'h00, 1'b1, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    DIR_T2, 8'h00, 1'b1, EV_CRCFAIL},
        // good one-byte frame, id and payload at the top of their range
        '{KIND_BYTE,    DS_LIT,    DIR_H1, 8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    DIR_H2, 8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'hFF,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'h01,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    8'hFF,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_CRC_LO, 8'h00,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_CRC_HI, 8'h00,  8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    DIR_T1, 8'h00, 1'b0, EV_NONE},
        '{KIND_BYTE,    DS_LIT,    DIR_T2, 8'h00, 1'b1, EV_ACCEPT},
        // held frame: bytes are dropped, payload reads back, then release
        '{KIND_BYTE,    DS_LIT,    8'h55,  8'h00, 1'b1, EV_IGNORED},
        '{KIND_READ,    DS_LIT,    8'hAA,  8'h00, 1'b0, EV_NONE},
        '{KIND_RELEASE, DS_LIT,    8'h00,  8'h00, 1'b1, EV_NONE}
    };

    // dut ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [7:0]  i_data_byte;
    logic [7:0]  i_read_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_event_res;
    logic        o_frame_ready;
    logic [7:0]  o_frm_id;
    logic [7:0]  o_frame_length;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_received_crc;

    // parser copy: registers, state and payload memory as the block should hold them
    t_cfg         rx_cfg;
    t_parse_state rx_state;
    logic         rx_ready;
    logic [7:0]   rx_id;
    logic [7:0]   rx_len;
    logic [7:0]   rx_count;
    logic [15:0]  rx_crc_run;
    logic [15:0]  rx_crc_got;
    logic [7:0]   rx_payload [PAYLOAD_DEPTH];
    bit           rx_written [PAYLOAD_DEPTH];
    int           n_written;

    t_rx_result results_due [$];   // result words owed by the block, oldest first
    int         words_in;          // accepted words, dropped bytes not counted
    int         results_seen;
    int         n_errors;
    bit         quiet;             // no idling on either side
    bit         hold_done;

    serial_frame_receiver_crc16_top uut (.*);

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // crc-16/xmodem, one data bit at a time, msb first
    function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // advance the parser copy by one accepted word and return the owed result
    function automatic t_rx_result frame_step(input logic [1:0] k, input logic [7:0] d,
                                              input logic [7:0] ix);
        t_rx_result r;
        r    = '0;
        r.ev = EV_NONE;
        if (k == KIND_BYTE && rx_ready) begin
            r.ev = EV_IGNORED;
        end else if (k == KIND_BYTE) begin
            case (rx_state)
                PS_HEAD0: begin
                    if (d == rx_cfg.header_first) rx_state = PS_HEAD1;
                end
                PS_HEAD1: begin
                    if (d == rx_cfg.header_second) begin
                        rx_state = PS_ID;
                    end else begin
                        rx_state = PS_HEAD0;
                        r.ev     = EV_FRAMEFAIL;
                    end
                end
                PS_ID: begin
                    rx_id    = d;
                    rx_state = PS_LEN;
                end
                PS_LEN: begin
                    rx_len     = d;
                    rx_count   = 8'd0;
                    rx_crc_run = 16'h0000;
                    // zero length skips straight to the crc bytes
                    rx_state   = (d == 8'd0) ? PS_CRC0 : PS_DATA;
                end
                PS_DATA: begin
                    rx_payload[rx_count] = d;
                    if (!rx_written[rx_count]) begin
                        rx_written[rx_count] = 1'b1;
                        n_written++;
                    end
                    rx_crc_run = crc_xmodem_byte(rx_crc_run, d);
                    rx_count   = rx_count + 8'd1;
                    if (rx_count >= rx_len) rx_state = PS_CRC0;
                end
                PS_CRC0: begin
                    rx_crc_got[7:0] = d;
                    rx_state        = PS_CRC1;
                end
                PS_CRC1: begin
                    rx_crc_got[15:8] = d;
                    rx_state         = PS_END0;
                end
                PS_END0: begin
                    if (d == rx_cfg.trailer_first) begin
                        rx_state = PS_END1;
                    end else begin
                        rx_state = PS_HEAD0;
                        r.ev     = EV_FRAMEFAIL;
                    end
                end
                PS_END1: begin
                    rx_state = PS_HEAD0;
                    if (d != rx_cfg.trailer_second) begin
                        r.ev = EV_FRAMEFAIL;
                    end else if (rx_cfg.crc_enable && rx_crc_run != rx_crc_got) begin
                        r.ev = EV_CRCFAIL;
                    end else begin
                        rx_ready = 1'b1;
                        r.ev     = EV_ACCEPT;
                    end
                end
                default: rx_state = PS_HEAD0;
            endcase
        end else if (k == KIND_READ) begin
            r.pb = rx_payload[ix];
        end else if (k == KIND_RELEASE) begin
            rx_ready = 1'b0;
        end
        r.rdy = rx_ready;
        r.id  = rx_id;
        r.len = rx_len;
        r.crc = rx_crc_got;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly short frames, now and then a long one
    function automatic int pick_length();
        if ($urandom_range(0, 99) == 0) return $urandom_range(128, 255);
        return $urandom_range(0, 12);
    endfunction

    // some payload entry already written; only called once one exists
    function automatic logic [7:0] any_written_index();
        logic [7:0] ix;
        ix = rand_byte();
        while (!rx_written[ix]) ix = ix + 8'd1;
        return ix;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_errors++;
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
    endtask

    // offer one word, hold it until taken, then book its expected result
    // valid is only lowered at the start of an idle burst, so it never
    // drops and rises within one step
    task automatic send_word(input logic [1:0] k, input logic [7:0] d, input logic [7:0] ix,
                             input logic typed, input logic [2:0] typed_ev);
        t_rx_result want;
        int         gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= k;
        i_data_byte  <= d;
        i_read_index <= ix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want = frame_step(k, d, ix);
        if (typed) want.ev = typed_ev;
        results_due.push_back(want);
        if (want.ev != EV_IGNORED) words_in++;
    endtask

    task automatic send_byte(input logic [7:0] d);
        send_word(KIND_BYTE, d, rand_byte(), 1'b0, EV_NONE);
    endtask

    task automatic send_release();
        send_word(KIND_RELEASE, rand_byte(), rand_byte(), 1'b0, EV_NONE);
    endtask

    // stop offering and wait for every owed result word
    task automatic await_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    // registers are written back to back, one per edge, with the block idle
    task automatic load_config(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEADER_FIRST;
        i_cfg_data  <= c.header_first;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEADER_SECOND;
        i_cfg_data  <= c.header_second;
        @(posedge i_clk);
        i_cfg_index <= CFG_TRAILER_FIRST;
        i_cfg_data  <= c.trailer_first;
        @(posedge i_clk);
        i_cfg_index <= CFG_TRAILER_SECOND;
        i_cfg_data  <= c.trailer_second;
        @(posedge i_clk);
        i_cfg_index <= CFG_CRC_ENABLE;
        i_cfg_data  <= {7'd0, c.crc_enable};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rx_cfg       = c;
    endtask

    // one frame from a clean start; a defect cuts it short or spoils one byte
    task automatic send_frame(input t_frame_defect defect, input int n);
        logic [7:0]  bad;
        logic [15:0] crc;
        bad = 8'($urandom_range(1, 255));
        // get the parser back to hunting with nothing held
        if (rx_ready) send_release();
        while (rx_state != PS_HEAD0) send_byte(rand_byte());
        if (rx_ready) send_release();

        send_byte(rx_cfg.header_first);
        if (defect == DF_HEADER2) begin
            send_byte(rx_cfg.header_second ^ bad);
            return;
        end
        send_byte(rx_cfg.header_second);
        send_byte(rand_byte());
        send_byte(8'(n));
        for (int i = 0; i < n; i++) begin
            send_byte(rand_byte());
            // read back the entry just stored, racing the memory write
            if ($urandom_range(0, 9) == 0)
                send_word(KIND_READ, rand_byte(), rx_count - 8'd1, 1'b0, EV_NONE);
        end
        crc = rx_crc_run;
        if (defect == DF_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        if (defect == DF_TRAILER1) begin
            send_byte(rx_cfg.trailer_first ^ bad);
            return;
        end
        send_byte(rx_cfg.trailer_first);
        send_byte((defect == DF_TRAILER2) ? (rx_cfg.trailer_second ^ bad)
                                          : rx_cfg.trailer_second);
    endtask

    // ------------------------------------------------------------------------
    // input side: reset, directed table, random phases, end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row  row;
        logic [7:0] d;
        t_cfg       cfg;
        int         phase_start;
        int         pick;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_HEADER_FIRST;
        i_cfg_data   = 8'h00;
        i_in_valid   = 1'b0;
        i_kind       = KIND_BYTE;
        i_data_byte  = 8'h00;
        i_read_index = 8'h00;

        // parser copy at reset
        rx_cfg     = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
        rx_state   = PS_HEAD0;
        rx_ready   = 1'b0;
        rx_id      = 8'h00;
        rx_len     = 8'h00;
        rx_count   = 8'h00;
        rx_crc_run = 16'h0000;
        rx_crc_got = 16'h0000;
        quiet      = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under fixed delimiters with the crc check on
        load_config('{DIR_H1, DIR_H2, DIR_T1, DIR_T2, 1'b1});
        for (int n = 0; n < $size(DIRECTED); n++) begin
            row = DIRECTED[n];
            case (row.src)
                DS_CRC_LO: d = rx_crc_run[7:0];
                DS_CRC_HI: d = rx_crc_run[15:8];
                default:   d = row.data;
            endcase
            send_word(row.kind, d, row.idx, row.typed, row.ev);
        end

        // random phases; each starts from an idle block with new registers
        for (int p = 0; p < N_RAND_PHASES; p++) begin
            await_results();
            case (p)
                0:       cfg = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
                1:       cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0};
                default: cfg = '{rand_byte(), rand_byte(), rand_byte(), rand_byte(), p[0]};
            endcase
            load_config(cfg);
            quiet       = (p == N_RAND_PHASES - 1);
            phase_start = words_in;
            // one frame as long as the length field allows
            if (p == 0) send_frame(DF_NONE, 255);
            while (words_in - phase_start < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                if (rx_ready) begin
                    // frame held: read it back, poke it, let it go
                    if (pick < 70 && rx_len != 8'd0)
                        send_word(KIND_READ, rand_byte(),
                                  8'($urandom_range(0, rx_len - 1)), 1'b0, EV_NONE);
                    else if (pick < 70 && n_written > 0)
                        send_word(KIND_READ, rand_byte(), any_written_index(),
                                  1'b0, EV_NONE);
                    else if (pick < 80)
                        send_byte(rand_byte());
                    else
                        send_release();
                end else if (pick < 65) begin
                    send_frame(DF_NONE, pick_length());
                end else if (pick < 80) begin
                    send_frame(t_frame_defect'($urandom_range(1, 4)), pick_length());
                end else if (pick < 92) begin
                    // line noise, often the first header byte itself
                    repeat ($urandom_range(1, 4))
                        send_byte((pick < 86) ? rx_cfg.header_first : rand_byte());
                end else begin
                    case ($urandom_range(0, 2))
                        0: send_release();
                        1: send_word(KIND_SPARE, rand_byte(), rand_byte(), 1'b0, EV_NONE);
                        default: begin
                            if (n_written > 0)
                                send_word(KIND_READ, rand_byte(), any_written_index(),
                                          1'b0, EV_NONE);
                            else
                                send_byte(rand_byte());
                        end
                    endcase
                end
            end
        end

        await_results();
        // keep the clock running to catch any stray result word
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random back-pressure plus one long hold-off that fills
    // the block and stalls its input while words keep being offered
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        i_out_ready = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && words_in >= HOLD_AT) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 9);
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // compare every taken result word against the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_rx_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result, event", 16'(o_event_res), 16'(EV_NONE));
            end else begin
                want = results_due.pop_front();
                if (o_event_res !== want.ev)
                    report_mismatch("event_res", 16'(o_event_res), 16'(want.ev));
                if (o_frame_ready !== want.rdy)
                    report_mismatch("frame_ready", 16'(o_frame_ready), 16'(want.rdy));
                if (o_frm_id !== want.id)
                    report_mismatch("frm_id", 16'(o_frm_id), 16'(want.id));
                if (o_frame_length !== want.len)
                    report_mismatch("frame_length", 16'(o_frame_length), 16'(want.len));
                if (o_payload_byte !== want.pb)
                    report_mismatch("payload_byte", 16'(o_payload_byte), 16'(want.pb));
                if (o_received_crc !== want.crc)
                    report_mismatch("received_crc", o_received_crc, want.crc);
            end
            results_seen++;
        end
    end

endmodule
